// ----- rtl/sisf_pkg.sv -----
// ----------------------------------------------------------------------------
// Segment intersection package
// Widths, result codes and shared types for the slope-form intersection unit.
// ----------------------------------------------------------------------------
package sisf_pkg;

  localparam int unsigned CoordBits = 32;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned TolBits   = 17;
  localparam logic [TolBits-1:0] TolReset = TolBits'(66);

  // Operand widths through the datapath.
  localparam int unsigned DBits   = CoordBits + 1;          // differences
  localparam int unsigned PBits   = 2 * DBits;              // products of two
  localparam int unsigned CBits   = PBits + 1;              // c terms, denominator
  localparam int unsigned NBits   = CBits + DBits + 1;      // numerator
  localparam int unsigned QBits   = NBits + 2;              // rounded quotient
  localparam int unsigned YNBits  = PBits + 2;              // y numerator

  // Divider shapes: dividend and quotient, divisor, and the data riding along.
  localparam int unsigned XNumBits  = QBits;
  localparam int unsigned XDenBits  = CBits + 1;
  localparam int unsigned XSideBits = 1 + PBits + 2 * DBits + 4 * CoordBits;
  localparam int unsigned YNumBits  = YNBits + 1;
  localparam int unsigned YDenBits  = DBits + 1;
  localparam int unsigned YSideBits = 3 + CoordBits;

  typedef enum logic [1:0] {
    OUT_HIT      = 2'd0,
    OUT_MISS     = 2'd1,
    OUT_DEGEN    = 2'd2,
    OUT_OVERFLOW = 2'd3
  } outcome_e;

  typedef struct packed {
    logic signed [CoordBits-1:0] first_start_x;
    logic signed [CoordBits-1:0] first_start_y;
    logic signed [CoordBits-1:0] first_end_x;
    logic signed [CoordBits-1:0] first_end_y;
    logic signed [CoordBits-1:0] second_start_x;
    logic signed [CoordBits-1:0] second_start_y;
    logic signed [CoordBits-1:0] second_end_x;
    logic signed [CoordBits-1:0] second_end_y;
  } seg_pair_t;

  typedef struct packed {
    outcome_e                    outcome;
    logic signed [CoordBits-1:0] cross_x;
    logic signed [CoordBits-1:0] cross_y;
  } cross_t;

endpackage

// ----- rtl/sisf_if.sv -----
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one payload beat of the given type per accepted handshake.
// ----------------------------------------------------------------------------
interface sisf_in_if;
  logic                 valid;
  logic                 ready;
  sisf_pkg::seg_pair_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sisf_out_if;
  logic              valid;
  logic              ready;
  sisf_pkg::cross_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/sisf_rdiv.sv -----
// ----------------------------------------------------------------------------
// Rounding dividers
// Pipelined restoring divides, one quotient bit per stage, of (2|n|+|d|)/(2|d|),
// one shaped for the crossing x and one for the crossing y.
// ----------------------------------------------------------------------------
module sisf_xdiv (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           adv_i,
  input  logic                           valid_i,
  input  logic [sisf_pkg::XNumBits-1:0]  num_i,
  input  logic [sisf_pkg::XDenBits-1:0]  den_i,
  input  logic                           neg_i,
  input  logic [sisf_pkg::XSideBits-1:0] side_i,
  output logic                           valid_o,
  output logic [sisf_pkg::XNumBits-1:0]  quo_o,
  output logic                           neg_o,
  output logic [sisf_pkg::XSideBits-1:0] side_o
);

  localparam int unsigned NumW  = sisf_pkg::XNumBits;
  localparam int unsigned DenW  = sisf_pkg::XDenBits;
  localparam int unsigned SideW = sisf_pkg::XSideBits;
  localparam int unsigned RemW  = DenW + 1;

  logic             vld_q  [NumW];
  logic [NumW-1:0]  num_q  [NumW];
  logic [RemW-1:0]  rem_q  [NumW];
  logic [DenW-1:0]  den_q  [NumW];
  logic             neg_q  [NumW];
  logic [SideW-1:0] side_q [NumW];

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic             vld_in;
    logic             neg_in;
    logic [NumW-1:0]  num_in;
    logic [RemW-1:0]  rem_in;
    logic [DenW-1:0]  den_in;
    logic [SideW-1:0] side_in;
    logic [RemW:0]    trial;
    logic             take;
    if (s == 0) begin : g_head
      assign vld_in  = valid_i;
      assign neg_in  = neg_i;
      assign num_in  = num_i;
      assign rem_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_tail
      assign vld_in  = vld_q[s-1];
      assign neg_in  = neg_q[s-1];
      assign num_in  = num_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
    end
    assign trial = {rem_in, num_in[NumW-1]};
    assign take  = trial >= {2'b00, den_in};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (adv_i) begin
        vld_q[s] <= vld_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s]  <= take ? RemW'(trial - {2'b00, den_in}) : RemW'(trial);
        num_q[s]  <= {num_in[NumW-2:0], take};
        den_q[s]  <= den_in;
        neg_q[s]  <= neg_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[NumW-1];
  assign quo_o   = num_q[NumW-1];
  assign neg_o   = neg_q[NumW-1];
  assign side_o  = side_q[NumW-1];

endmodule

module sisf_ydiv (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           adv_i,
  input  logic                           valid_i,
  input  logic [sisf_pkg::YNumBits-1:0]  num_i,
  input  logic [sisf_pkg::YDenBits-1:0]  den_i,
  input  logic                           neg_i,
  input  logic [sisf_pkg::YSideBits-1:0] side_i,
  output logic                           valid_o,
  output logic [sisf_pkg::YNumBits-1:0]  quo_o,
  output logic                           neg_o,
  output logic [sisf_pkg::YSideBits-1:0] side_o
);

  localparam int unsigned NumW  = sisf_pkg::YNumBits;
  localparam int unsigned DenW  = sisf_pkg::YDenBits;
  localparam int unsigned SideW = sisf_pkg::YSideBits;
  localparam int unsigned RemW  = DenW + 1;

  logic             vld_q  [NumW];
  logic [NumW-1:0]  num_q  [NumW];
  logic [RemW-1:0]  rem_q  [NumW];
  logic [DenW-1:0]  den_q  [NumW];
  logic             neg_q  [NumW];
  logic [SideW-1:0] side_q [NumW];

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic             vld_in;
    logic             neg_in;
    logic [NumW-1:0]  num_in;
    logic [RemW-1:0]  rem_in;
    logic [DenW-1:0]  den_in;
    logic [SideW-1:0] side_in;
    logic [RemW:0]    trial;
    logic             take;
    if (s == 0) begin : g_head
      assign vld_in  = valid_i;
      assign neg_in  = neg_i;
      assign num_in  = num_i;
      assign rem_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_tail
      assign vld_in  = vld_q[s-1];
      assign neg_in  = neg_q[s-1];
      assign num_in  = num_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
    end
    assign trial = {rem_in, num_in[NumW-1]};
    assign take  = trial >= {2'b00, den_in};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (adv_i) begin
        vld_q[s] <= vld_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s]  <= take ? RemW'(trial - {2'b00, den_in}) : RemW'(trial);
        num_q[s]  <= {num_in[NumW-2:0], take};
        den_q[s]  <= den_in;
        neg_q[s]  <= neg_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[NumW-1];
  assign quo_o   = num_q[NumW-1];
  assign neg_o   = neg_q[NumW-1];
  assign side_o  = side_q[NumW-1];

endmodule

// ----- rtl/segment_intersection_slope_form_unit.sv -----
// ----------------------------------------------------------------------------
// Segment intersection, slope form
// Intersects the lines through two segments and tests the crossing spans.
// ----------------------------------------------------------------------------
// Input beat to result beat: stages 1-5, x divider, stages 6-8, y divider, output.
// Throughput: one beat per cycle; the pipeline stalls as a whole when the
// output holds a beat that is not taken. The two bit-per-stage dividers set
// the depth. Reset clears all valid bits and loads tol_q with 66.
module segment_intersection_slope_form_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sisf_pkg::TolBits-1:0]        cfg_wdata_i,
  sisf_in_if.sink                             in_if,
  sisf_out_if.source                          out_if
);

  localparam int unsigned CW  = sisf_pkg::CoordBits;
  localparam int unsigned DW  = sisf_pkg::DBits;
  localparam int unsigned PW  = sisf_pkg::PBits;
  localparam int unsigned CB  = sisf_pkg::CBits;
  localparam int unsigned NW  = sisf_pkg::NBits;
  localparam int unsigned QW  = sisf_pkg::QBits;
  localparam int unsigned YW  = sisf_pkg::YNBits;
  localparam int unsigned TW  = sisf_pkg::TolBits;

  logic [TW-1:0] tol_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= sisf_pkg::TolReset;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // Whole pipeline advances together unless a result is stuck at the output.
  logic adv;
  assign adv = !out_if.valid || out_if.ready;
  assign in_if.ready = adv;

  // ---- Stage 1: differences.
  logic                 v1_q;
  logic signed [DW-1:0] dx1_q, dy1_q, dx2_q, dy2_q;
  logic signed [CW-1:0] ax1_q, ay1_q, ax2_q, bx1_q, by1_q, bx2_q;
  sisf_pkg::seg_pair_t  p;
  assign p = in_if.data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= in_if.valid;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx1_q <= DW'(p.first_end_x) - DW'(p.first_start_x);
      dy1_q <= DW'(p.first_end_y) - DW'(p.first_start_y);
      dx2_q <= DW'(p.second_end_x) - DW'(p.second_start_x);
      dy2_q <= DW'(p.second_end_y) - DW'(p.second_start_y);
      ax1_q <= p.first_start_x;  ay1_q <= p.first_start_y;
      ax2_q <= p.first_end_x;    bx1_q <= p.second_start_x;
      by1_q <= p.second_start_y; bx2_q <= p.second_end_x;
    end
  end

  // ---- Stage 2: six products.
  logic                 v2_q;
  logic signed [PW-1:0] m_dy1dx2_q, m_dy2dx1_q, m_ay1dx1_q, m_dy1ax1_q;
  logic signed [PW-1:0] m_by1dx2_q, m_dy2bx1_q;
  logic signed [DW-1:0] dx1_2q, dx2_2q, dy1_2q;
  logic signed [CW-1:0] ax1_2q, ax2_2q, bx1_2q, bx2_2q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_dy1dx2_q <= PW'(dy1_q) * PW'(dx2_q);
      m_dy2dx1_q <= PW'(dy2_q) * PW'(dx1_q);
      m_ay1dx1_q <= PW'(ay1_q) * PW'(dx1_q);
      m_dy1ax1_q <= PW'(dy1_q) * PW'(ax1_q);
      m_by1dx2_q <= PW'(by1_q) * PW'(dx2_q);
      m_dy2bx1_q <= PW'(dy2_q) * PW'(bx1_q);
      dx1_2q <= dx1_q;
      dx2_2q <= dx2_q; dy1_2q <= dy1_q;
      ax1_2q <= ax1_q; ax2_2q <= ax2_q;
      bx1_2q <= bx1_q; bx2_2q <= bx2_q;
    end
  end

  // ---- Stage 3: denominator and c terms.
  logic                 v3_q;
  logic signed [CB-1:0] den_q, c1_q, c2_q;
  logic signed [PW-1:0] aydx_3q;
  logic signed [DW-1:0] dx1_3q, dx2_3q, dy1_3q;
  logic signed [CW-1:0] ax1_3q, ax2_3q, bx1_3q, bx2_3q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      den_q <= CB'(m_dy1dx2_q) - CB'(m_dy2dx1_q);
      c1_q  <= CB'(m_ay1dx1_q) - CB'(m_dy1ax1_q);
      c2_q  <= CB'(m_by1dx2_q) - CB'(m_dy2bx1_q);
      aydx_3q <= m_ay1dx1_q;
      dx1_3q <= dx1_2q; dx2_3q <= dx2_2q; dy1_3q <= dy1_2q;
      ax1_3q <= ax1_2q; ax2_3q <= ax2_2q; bx1_3q <= bx1_2q; bx2_3q <= bx2_2q;
    end
  end

  // ---- Stage 4: c by dx products, cut in halves of dx to keep multipliers narrow.
  localparam int unsigned HL = DW / 2;
  localparam int unsigned MW = CB + DW;
  logic                 v4_q;
  logic signed [MW-1:0] c2lo_q, c2hi_q, c1lo_q, c1hi_q;
  logic signed [CB-1:0] den_4q;
  logic signed [PW-1:0] aydx_4q;
  logic signed [DW-1:0] dx1_4q, dx2_4q, dy1_4q;
  logic signed [CW-1:0] ax1_4q, ax2_4q, bx1_4q, bx2_4q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (adv) v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      c2lo_q <= MW'(c2_q) * $signed(MW'({1'b0, dx1_3q[HL-1:0]}));
      c2hi_q <= MW'(c2_q) * MW'($signed(dx1_3q[DW-1:HL]));
      c1lo_q <= MW'(c1_q) * $signed(MW'({1'b0, dx2_3q[HL-1:0]}));
      c1hi_q <= MW'(c1_q) * MW'($signed(dx2_3q[DW-1:HL]));
      den_4q <= den_q; aydx_4q <= aydx_3q;
      dx1_4q <= dx1_3q; dx2_4q <= dx2_3q; dy1_4q <= dy1_3q;
      ax1_4q <= ax1_3q; ax2_4q <= ax2_3q; bx1_4q <= bx1_3q; bx2_4q <= bx2_3q;
    end
  end

  // ---- Stage 5: numerator, signs, magnitudes, degenerate check.
  logic                 v5_q;
  logic [NW:0]          nmag_q;
  logic [CB-1:0]        dmag_q;
  logic                 xneg_q, degen_q;
  logic signed [NW-1:0] num_d;
  logic signed [PW-1:0] aydx_5q;
  logic signed [DW-1:0] dx1_5q, dy1_5q;
  logic signed [CW-1:0] ax1_5q, ax2_5q, bx1_5q, bx2_5q;
  assign num_d = (NW'(c2lo_q) + (NW'(c2hi_q) <<< HL))
               - (NW'(c1lo_q) + (NW'(c1hi_q) <<< HL));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (adv) v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      nmag_q  <= num_d[NW-1] ? (NW+1)'(-num_d) : (NW+1)'(num_d);
      dmag_q  <= den_4q[CB-1] ? CB'(-den_4q) : CB'(den_4q);
      xneg_q  <= num_d[NW-1] ^ den_4q[CB-1];
      degen_q <= (dx1_4q == '0) || (dx2_4q == '0) || (den_4q == '0);
      aydx_5q <= aydx_4q; dx1_5q <= dx1_4q; dy1_5q <= dy1_4q;
      ax1_5q <= ax1_4q; ax2_5q <= ax2_4q; bx1_5q <= bx1_4q; bx2_5q <= bx2_4q;
    end
  end

  // ---- Divider for x. Degenerate items divide by 1 to stay well defined.
  localparam int unsigned XSW = sisf_pkg::XSideBits;
  logic [QW-1:0]   xq;
  logic            xv, xneg_o;
  logic [XSW-1:0]  xside;
  logic [CB:0]     xden;
  assign xden = degen_q ? (CB+1)'(2) : {dmag_q, 1'b0};

  sisf_xdiv u_xdiv (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(v5_q),
    .num_i(QW'({nmag_q, 1'b0}) + QW'(xden[CB:1])),
    .den_i(xden), .neg_i(xneg_q),
    .side_i({degen_q, aydx_5q, dx1_5q, dy1_5q, ax1_5q, ax2_5q, bx1_5q, bx2_5q}),
    .valid_o(xv), .quo_o(xq), .neg_o(xneg_o), .side_o(xside)
  );

  logic                 s6_degen;
  logic signed [PW-1:0] s6_aydx;
  logic signed [DW-1:0] s6_dx1, s6_dy1;
  logic signed [CW-1:0] s6_ax1, s6_ax2, s6_bx1, s6_bx2;
  assign {s6_degen, s6_aydx, s6_dx1, s6_dy1, s6_ax1, s6_ax2, s6_bx1, s6_bx2} = xside;

  // ---- Stage 6: range check of x and span test.
  localparam logic [QW-1:0] PosLim = QW'({1'b0, {(CW-1){1'b1}}});
  localparam logic [QW-1:0] NegLim = QW'({1'b1, {(CW-1){1'b0}}});
  logic                  v6_q, ok6_q;
  sisf_pkg::outcome_e    oc6_q;
  logic signed [CW-1:0]  x6_q;
  logic signed [PW-1:0]  aydx_6q;
  logic signed [DW-1:0]  dx1_6q, dy1_6q;
  logic signed [CW-1:0]  ax1_6q;
  logic                  xrange;
  logic signed [CW-1:0]  xs;
  logic signed [CW+1:0]  xe, lo1, hi1, lo2, hi2, te;
  logic                  span_ok;

  assign xrange = xneg_o ? (xq <= NegLim) : (xq <= PosLim);
  assign xs     = xneg_o ? CW'(-xq[CW-1:0]) : xq[CW-1:0];
  assign xe     = (CW+2)'(xs);
  assign te     = (CW+2)'($signed({1'b0, tol_q}));
  assign lo1 = (s6_ax1 < s6_ax2) ? (CW+2)'(s6_ax1) - te : (CW+2)'(s6_ax2) - te;
  assign hi1 = (s6_ax1 < s6_ax2) ? (CW+2)'(s6_ax2) + te : (CW+2)'(s6_ax1) + te;
  assign lo2 = (s6_bx1 < s6_bx2) ? (CW+2)'(s6_bx1) - te : (CW+2)'(s6_bx2) - te;
  assign hi2 = (s6_bx1 < s6_bx2) ? (CW+2)'(s6_bx2) + te : (CW+2)'(s6_bx1) + te;
  assign span_ok = (xe >= lo1) && (xe <= hi1) && (xe >= lo2) && (xe <= hi2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (adv) v6_q <= xv;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      priority if (s6_degen) begin
        oc6_q <= sisf_pkg::OUT_DEGEN; ok6_q <= 1'b0;
      end else if (!xrange) begin
        oc6_q <= sisf_pkg::OUT_OVERFLOW; ok6_q <= 1'b0;
      end else if (!span_ok) begin
        oc6_q <= sisf_pkg::OUT_MISS; ok6_q <= 1'b0;
      end else begin
        oc6_q <= sisf_pkg::OUT_HIT; ok6_q <= 1'b1;
      end
      x6_q <= xs; aydx_6q <= s6_aydx; dx1_6q <= s6_dx1; dy1_6q <= s6_dy1;
      ax1_6q <= s6_ax1;
    end
  end

  // ---- Stage 7: dy1 * (x - ax1).
  logic                  v7_q, ok7_q;
  sisf_pkg::outcome_e    oc7_q;
  logic signed [CW-1:0]  x7_q;
  logic signed [PW-1:0]  aydx_7q, prod7_q;
  logic signed [DW-1:0]  dx1_7q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else if (adv) v7_q <= v6_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod7_q <= PW'(dy1_6q) * (PW'(x6_q) - PW'(ax1_6q));
      ok7_q <= ok6_q; oc7_q <= oc6_q; x7_q <= x6_q;
      aydx_7q <= aydx_6q; dx1_7q <= dx1_6q;
    end
  end

  // ---- Stage 8: y numerator sign and magnitude.
  logic                  v8_q, ok8_q, yneg_q;
  sisf_pkg::outcome_e    oc8_q;
  logic signed [CW-1:0]  x8_q;
  logic [YW-1:0]         ymag_q;
  logic [DW-1:0]         dxm_q;
  logic signed [YW-1:0]  ny;
  assign ny = YW'(aydx_7q) + YW'(prod7_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v8_q <= 1'b0;
    else if (adv) v8_q <= v7_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ymag_q <= ny[YW-1] ? YW'(-ny) : YW'(ny);
      dxm_q  <= (!ok7_q) ? DW'(1) : (dx1_7q[DW-1] ? DW'(-dx1_7q) : DW'(dx1_7q));
      yneg_q <= ny[YW-1] ^ dx1_7q[DW-1];
      ok8_q <= ok7_q; oc8_q <= oc7_q; x8_q <= x7_q;
    end
  end

  // ---- Divider for y.
  localparam int unsigned YQ  = sisf_pkg::YNumBits;
  localparam int unsigned YSW = sisf_pkg::YSideBits;
  logic [YQ-1:0]   yq;
  logic            yv, yneg_o;
  logic [YSW-1:0]  yside;

  sisf_ydiv u_ydiv (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(v8_q),
    .num_i({ymag_q, 1'b0} + YQ'(dxm_q)),
    .den_i({dxm_q, 1'b0}), .neg_i(yneg_q),
    .side_i({ok8_q, oc8_q, x8_q}),
    .valid_o(yv), .quo_o(yq), .neg_o(yneg_o), .side_o(yside)
  );

  logic                  s9_ok;
  logic [1:0]            s9_oc;
  logic signed [CW-1:0]  s9_x;
  logic                  yrange;
  assign {s9_ok, s9_oc, s9_x} = yside;
  assign yrange = yneg_o ? (yq <= YQ'(NegLim[CW-1:0])) : (yq <= YQ'(PosLim[CW-1:0]));

  // ---- Output register.
  logic              ov_q;
  sisf_pkg::cross_t  od_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (adv) ov_q <= yv;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (s9_ok && yrange) begin
        od_q.outcome <= sisf_pkg::OUT_HIT;
        od_q.cross_x <= s9_x;
        od_q.cross_y <= yneg_o ? CW'(-yq[CW-1:0]) : yq[CW-1:0];
      end else begin
        od_q.outcome <= s9_ok ? sisf_pkg::OUT_OVERFLOW : sisf_pkg::outcome_e'(s9_oc);
        od_q.cross_x <= '0;
        od_q.cross_y <= '0;
      end
    end
  end

  assign out_if.valid = ov_q;
  assign out_if.data  = od_q;

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// Slope-form segment intersection testbench
// Streams segment pairs through the unit under random valid/ready gaps and
// compares every result beat against a wide-integer prediction in the bench.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned DrainCycles = 400;
  localparam int unsigned WatchLimit  = 20000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [sisf_pkg::TolBits-1:0] cfg_wdata_i;

  sisf_in_if  in_if ();
  sisf_out_if out_if ();

  segment_intersection_slope_form_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  sisf_pkg::seg_pair_t          pair_queue[$];
  sisf_pkg::cross_t             crossing_queue[$];
  logic [sisf_pkg::TolBits-1:0] tol_model;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  int unsigned  error_count;
  int unsigned  idle_cycles;
  bit           run_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Rounded quotient, ties away from zero; ok is cleared when it leaves range.
  function automatic logic signed [sisf_pkg::CoordBits-1:0] round_quot(
    input logic signed [255:0] n, input logic signed [255:0] d, output bit ok);
    logic [255:0] an, ad, q;
    bit neg;
    neg = (n < 0) != (d < 0);
    an  = (n < 0) ? -n : n;
    ad  = (d < 0) ? -d : d;
    q   = ((an << 1) + ad) / (ad << 1);
    ok  = neg ? (q <= 256'(64'h8000_0000)) : (q <= 256'(64'h7fff_ffff));
    return neg ? -q[sisf_pkg::CoordBits-1:0] : q[sisf_pkg::CoordBits-1:0];
  endfunction

  function automatic sisf_pkg::cross_t predict_crossing(
    input sisf_pkg::seg_pair_t p, input logic [sisf_pkg::TolBits-1:0] tol);
    sisf_pkg::cross_t r;
    logic signed [255:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
    logic signed [255:0] dx1, dy1, dx2, dy2, den, c1, c2, num, xw, lo, hi, tw, ny;
    logic signed [sisf_pkg::CoordBits-1:0] xq, yq;
    bit ok, span_ok;
    ax1 = p.first_start_x;  ay1 = p.first_start_y;
    ax2 = p.first_end_x;    ay2 = p.first_end_y;
    bx1 = p.second_start_x; by1 = p.second_start_y;
    bx2 = p.second_end_x;   by2 = p.second_end_y;
    dx1 = ax2 - ax1; dy1 = ay2 - ay1;
    dx2 = bx2 - bx1; dy2 = by2 - by1;
    tw  = $signed({1'b0, tol});
    r.outcome = sisf_pkg::OUT_DEGEN;
    r.cross_x = '0;
    r.cross_y = '0;
    den = dy1 * dx2 - dy2 * dx1;
    if (dx1 == 0 || dx2 == 0 || den == 0) return r;
    c1  = ay1 * dx1 - dy1 * ax1;
    c2  = by1 * dx2 - dy2 * bx1;
    num = c2 * dx1 - c1 * dx2;
    xq  = round_quot(num, den, ok);
    if (!ok) begin
      r.outcome = sisf_pkg::OUT_OVERFLOW;
      return r;
    end
    xw = xq;
    lo = (ax1 < ax2) ? ax1 : ax2;
    hi = (ax1 < ax2) ? ax2 : ax1;
    span_ok = (xw >= lo - tw) && (xw <= hi + tw);
    lo = (bx1 < bx2) ? bx1 : bx2;
    hi = (bx1 < bx2) ? bx2 : bx1;
    span_ok = span_ok && (xw >= lo - tw) && (xw <= hi + tw);
    if (!span_ok) begin
      r.outcome = sisf_pkg::OUT_MISS;
      return r;
    end
    ny = ay1 * dx1 + dy1 * (xw - ax1);
    yq = round_quot(ny, dx1, ok);
    if (!ok) begin
      r.outcome = sisf_pkg::OUT_OVERFLOW;
      return r;
    end
    r.outcome = sisf_pkg::OUT_HIT;
    r.cross_x = xq;
    r.cross_y = yq;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  function automatic logic [31:0] rand_coord(input int unsigned mode);
    unique case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 2 * 65536 * 20) - 65536 * 20;
      2: return $urandom_range(0, 4000) - 2000;
      default: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom)};
    endcase
  endfunction

  function automatic sisf_pkg::seg_pair_t rand_pair();
    sisf_pkg::seg_pair_t p;
    int unsigned mode;
    int signed cx, cy, d;
    mode = $urandom_range(0, 9);
    p.first_start_x = rand_coord(mode % 4);
    p.first_start_y = rand_coord(mode % 4);
    p.first_end_x = rand_coord(mode % 4);
    p.first_end_y = rand_coord(mode % 4);
    p.second_start_x = rand_coord(mode % 4);
    p.second_start_y = rand_coord(mode % 4);
    p.second_end_x = rand_coord(mode % 4);
    p.second_end_y = rand_coord(mode % 4);
    if (mode >= 4 && mode <= 7) begin
      // Segments built around a common point, so most of these cross.
      cx = $urandom_range(0, 2000000) - 1000000;
      cy = $urandom_range(0, 2000000) - 1000000;
      d  = $urandom_range(1, 300000);
      p.first_start_x = cx - d;
      p.first_end_x = cx + $urandom_range(0, 300000);
      p.first_start_y = cy - $urandom_range(0, 300000);
      p.first_end_y = cy + $urandom_range(0, 300000);
      p.second_start_x = cx + $urandom_range(0, 300000);
      p.second_end_x = cx - $urandom_range(1, 300000);
      p.second_start_y = cy - $urandom_range(0, 300000);
      p.second_end_y = cy + $urandom_range(0, 300000);
    end else if (mode == 8) begin
      if ($urandom_range(0, 1)) p.first_end_x = p.first_start_x;
      else p.second_end_x = p.second_start_x;
    end
    return p;
  endfunction

  function automatic sisf_pkg::seg_pair_t make_pair(input int signed a0, a1, a2, a3,
                                                    input int signed b0, b1, b2, b3);
    sisf_pkg::seg_pair_t p;
    p.first_start_x = a0;  p.first_start_y = a1;
    p.first_end_x = a2;    p.first_end_y = a3;
    p.second_start_x = b0; p.second_start_y = b1;
    p.second_end_x = b2;   p.second_end_y = b3;
    return p;
  endfunction

  task automatic wait_idle();
    while (pair_queue.size() != 0 || crossing_queue.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_tolerance(input logic [sisf_pkg::TolBits-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) pair_queue.push_back(rand_pair());
    wait_idle();
  endtask

  localparam int signed Mx = 32'h7fffffff;
  localparam int signed Mn = 32'h80000000;

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    tol_model     = sisf_pkg::TolReset;
    send_idle_pct = 25;
    recv_idle_pct = 52;
    error_count   = 0;
    run_done      = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: plain crossing, touching ends, vertical, parallel, collinear,
    // extreme coordinates, overflowing crossings and tolerance edge.
    pair_queue.push_back(make_pair(0, 0, 65536, 65536, 0, 65536, 65536, 0));
    pair_queue.push_back(make_pair(0, 0, 100, 100, 100, 100, 200, 0));
    pair_queue.push_back(make_pair(5, 0, 5, 100, 0, 3, 10, 7));
    pair_queue.push_back(make_pair(0, 0, 10, 10, 0, 3, 10, 7 - 4 + 10));
    pair_queue.push_back(make_pair(0, 0, 10, 10, 0, 5, 10, 15));
    pair_queue.push_back(make_pair(0, 0, 10, 10, 20, 20, 30, 30));
    pair_queue.push_back(make_pair(Mn, Mn, Mx, Mx, Mn, Mx, Mx, Mn));
    pair_queue.push_back(make_pair(Mx, Mn, Mn, Mx, Mx, Mx, Mn, Mn));
    pair_queue.push_back(make_pair(Mn, 0, Mx, 1, Mn, 0, Mx, 2));
    pair_queue.push_back(make_pair(0, 0, 1, 1, 0, 1, 1, 3));
    pair_queue.push_back(make_pair(0, 0, 2, Mx, 0, 1, 2, Mn));
    pair_queue.push_back(make_pair(Mn, Mx, Mn + 1, Mn, Mx, Mx, Mx - 1, Mn));
    pair_queue.push_back(make_pair(0, 0, 100, 0, 166, -10, 180, 10));
    pair_queue.push_back(make_pair(0, 0, 100, 0, 167, -10, 180, 10));
    pair_queue.push_back(make_pair(-1, -1, -1000, 3, 7, 7, -7, -7));
    pair_queue.push_back(make_pair(0, Mx, 1, Mn, 0, Mn, 1, Mx));
    pair_queue.push_back(make_pair(1, 1, 4, 2, 1, 2, 4, 1));
    pair_queue.push_back(make_pair(0, 0, 3, 1, 0, 1, 3, 0));
    wait_idle();

    run_phase(300);
    write_tolerance('0);
    run_phase(150);
    send_idle_pct = 52;
    recv_idle_pct = 25;
    write_tolerance(17'd65536);
    run_phase(200);
    write_tolerance(17'h1ffff);
    run_phase(100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_tolerance(17'($urandom_range(0, 65536)));
    run_phase(200);
    run_done = 1'b1;
  end

  always @(posedge clk_i) begin
    if (cfg_we_i) tol_model <= cfg_wdata_i;
  end

  // Driver: the valid line only drops once the current beat is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        crossing_queue.push_back(predict_crossing(in_if.data, tol_model));
        void'(pair_queue.pop_front());
      end
      if (!in_if.valid || in_if.ready) begin
        if (pair_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_if.valid <= 1'b1;
          in_if.data  <= pair_queue[0];
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor with random backpressure.
  always @(posedge clk_i or negedge rst_ni) begin
    sisf_pkg::cross_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (out_if.valid && out_if.ready) begin
        if (crossing_queue.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = crossing_queue.pop_front();
          if (out_if.data.outcome != want.outcome)
            report_mismatch($sformatf("outcome got %0d want %0d",
                                      out_if.data.outcome, want.outcome));
          if (out_if.data.cross_x != want.cross_x)
            report_mismatch($sformatf("cross_x got %0d want %0d",
                                      out_if.data.cross_x, want.cross_x));
          if (out_if.data.cross_y != want.cross_y)
            report_mismatch($sformatf("cross_y got %0d want %0d",
                                      out_if.data.cross_y, want.cross_y));
        end
      end
    end
  end

  // Watchdog and end of run. The count runs while any beat is still owed.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (pair_queue.size() == 0 && crossing_queue.size() == 0))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("FAILURE");
        $finish;
      end else if (run_done) begin
        if (error_count == 0 && crossing_queue.size() == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
      end
    end
  end

endmodule
